// ===== src/mss_pkg.sv =====
package mss_pkg;

  // Data store depth in words; must be a power of two (16 .. 65536).
  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned DS_AW      = $clog2(DATA_WORDS);

  localparam int unsigned RF_DEPTH = 32;
  localparam int unsigned RF_AW    = 5;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 80;

  // Major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_NORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL funct codes
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;

  // Syscall codes
  localparam logic [7:0] SYS_PRINT_INT    = 8'd1;
  localparam logic [7:0] SYS_PRINT_STRING = 8'd4;
  localparam logic [7:0] SYS_INPUT_INT    = 8'd5;
  localparam logic [7:0] SYS_READ_STRING  = 8'd8;
  localparam logic [7:0] SYS_EXIT         = 8'd10;
  localparam logic [7:0] SYS_PRINT_CHAR   = 8'd11;
  localparam logic [7:0] SYS_READ_CHAR    = 8'd12;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_BADCALL = 3'd2;
  localparam logic [2:0] ST_EVENT   = 3'd3;
  localparam logic [2:0] ST_HALTED  = 3'd4;

  // Fixed register numbers
  localparam logic [RF_AW-1:0] REG_ZERO = 5'd0;
  localparam logic [RF_AW-1:0] REG_V0   = 5'd2;
  localparam logic [RF_AW-1:0] REG_A0   = 5'd4;
  localparam logic [RF_AW-1:0] REG_RA   = 5'd31;

  // Everything one instruction does, as worked out in execute
  typedef struct packed {
    logic [31:0]      next_pc;
    logic [2:0]       status;
    logic [7:0]       call_code;
    logic [31:0]      call_arg;
    logic             wr_en;
    logic [RF_AW-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic             is_load;
    logic             ds_we;
    logic [DS_AW-1:0] ds_addr;
    logic [31:0]      ds_wdata;
    logic             halt_set;
  } ex_res_t;

endpackage

// ===== src/mips_subset_instruction_step_top.sv =====
// Channel   Dir  Beat content (tdata, lowest bit up)
// s_axis    in   instr_word[31:0], console_value[63:32]
// m_axis    out  next_pc[31:0], status[34:32], call_code[42:35],
//                call_argument[74:43], zero fill [79:75]
//
// One instruction per clock while m_axis is not stalled and no clearing pass
// runs; an accepted beat passes the register file read, data store read and
// result registers in that order before it shows up on m_axis. After reset a
// clearing pass zeroes all DATA_WORDS data store words with s_axis_tready_o low.
// A stall on m_axis freezes the whole pipeline; RAM reads are reissued at
// the held addresses so no read data is lost.
module mips_subset_instruction_step_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // instr_word[31:0], console_value[63:32]
  input  logic [mss_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // next_pc[31:0], status[34:32], call_code[42:35], call_argument[74:43]
  output logic [mss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned AW = mss_pkg::RF_AW;
  localparam int unsigned DW = mss_pkg::DS_AW;

  // global advance: the result register can take a new beat
  logic adv;
  logic accept;

  // ---------------- clearing pass ----------------
  logic          clr_busy_q;
  logic [DW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == DW'(mss_pkg::DATA_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------- accept / operand fetch ----------------
  logic [31:0]   in_instr;
  logic [31:0]   in_cval;
  logic          in_is_sys;
  logic [AW-1:0] ra_new;
  logic [AW-1:0] rb_new;
  logic [AW-1:0] ra_rd;
  logic [AW-1:0] rb_rd;
  logic [AW-1:0] ra_q;
  logic [AW-1:0] rb_q;

  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv && !clr_busy_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_instr  = s_axis_tdata_i[31:0];
  assign in_cval   = s_axis_tdata_i[63:32];
  // syscall reads $v0 and $a0 through the two read ports
  assign in_is_sys = (in_instr[31:26] == mss_pkg::OP_SPECIAL) &&
                     (in_instr[5:0] == mss_pkg::FN_SYSCALL);
  assign ra_new    = in_is_sys ? mss_pkg::REG_V0 : in_instr[25:21];
  assign rb_new    = in_is_sys ? mss_pkg::REG_A0 : in_instr[20:16];
  assign ra_rd     = adv ? ra_new : ra_q;
  assign rb_rd     = adv ? rb_new : rb_q;

  // ---------------- register file ----------------
  logic                rf_we;
  logic [AW-1:0]       rf_waddr;
  logic [31:0]         rf_wdata;
  logic [31:0]         rf_a_rdata;
  logic [31:0]         rf_b_rdata;
  logic [mss_pkg::RF_DEPTH-1:0] rf_vld_q;
  logic                rf_va_q;
  logic                rf_vb_q;

  mss_ram #(
    .Width(32),
    .Depth(mss_pkg::RF_DEPTH)
  ) u_rf_a (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .raddr_i(ra_rd),
    .rdata_o(rf_a_rdata)
  );

  mss_ram #(
    .Width(32),
    .Depth(mss_pkg::RF_DEPTH)
  ) u_rf_b (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .raddr_i(rb_rd),
    .rdata_o(rf_b_rdata)
  );

  // entries never written read as zero; looked up in step with the RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      rf_va_q  <= 1'b0;
      rf_vb_q  <= 1'b0;
    end else begin
      rf_va_q <= rf_vld_q[ra_rd];
      rf_vb_q <= rf_vld_q[rb_rd];
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
    end
  end

  // ---------------- execute stage ----------------
  logic             ex_valid_q;
  logic [31:0]      ex_instr_q;
  logic [31:0]      ex_cval_q;
  logic [31:0]      pc_q;
  logic             halted_q;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  mss_pkg::ex_res_t ex_res;

  // memory stage
  logic             mem_valid_q;
  mss_pkg::ex_res_t mem_q;
  logic [31:0]      mem_wdata;

  // last register write, not yet visible in RAM read data
  logic             last_we_q;
  logic [AW-1:0]    last_waddr_q;
  logic [31:0]      last_wdata_q;

  // data store
  logic             ds_we;
  logic [DW-1:0]    ds_waddr;
  logic [31:0]      ds_wdata;
  logic [DW-1:0]    ds_raddr;
  logic [DW-1:0]    ds_raddr_q;
  logic [31:0]      ds_rdata;

  assign mem_wdata = mem_q.is_load ? ds_rdata : mem_q.wr_data;

  // forwarding: memory stage first, then the last write, then the RAM
  always_comb begin
    op_a = rf_va_q ? rf_a_rdata : 32'd0;
    op_b = rf_vb_q ? rf_b_rdata : 32'd0;
    if (last_we_q && (last_waddr_q == ra_q)) begin
      op_a = last_wdata_q;
    end
    if (last_we_q && (last_waddr_q == rb_q)) begin
      op_b = last_wdata_q;
    end
    if (mem_valid_q && mem_q.wr_en && (mem_q.wr_addr == ra_q)) begin
      op_a = mem_wdata;
    end
    if (mem_valid_q && mem_q.wr_en && (mem_q.wr_addr == rb_q)) begin
      op_b = mem_wdata;
    end
  end

  mss_exec u_exec (
    .instr_i (ex_instr_q),
    .cval_i  (ex_cval_q),
    .a_i     (op_a),
    .b_i     (op_b),
    .pc_i    (pc_q),
    .halted_i(halted_q),
    .res_o   (ex_res)
  );

  // store writes from execute; the load read is issued from execute too
  assign ds_we    = clr_busy_q || (adv && ex_valid_q && ex_res.ds_we);
  assign ds_waddr = clr_busy_q ? clr_cnt_q : ex_res.ds_addr;
  assign ds_wdata = clr_busy_q ? 32'd0 : ex_res.ds_wdata;
  assign ds_raddr = adv ? ex_res.ds_addr : ds_raddr_q;

  mss_ram #(
    .Width(32),
    .Depth(mss_pkg::DATA_WORDS)
  ) u_ds (
    .clk_i  (clk_i),
    .we_i   (ds_we),
    .waddr_i(ds_waddr),
    .wdata_i(ds_wdata),
    .raddr_i(ds_raddr),
    .rdata_o(ds_rdata)
  );

  // register file write from the memory stage
  assign rf_we    = adv && mem_valid_q && mem_q.wr_en;
  assign rf_waddr = mem_q.wr_addr;
  assign rf_wdata = mem_wdata;

  // ---------------- pipeline registers ----------------
  logic                            m_valid_q;
  logic [mss_pkg::OUT_TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      mem_valid_q <= 1'b0;
      m_valid_q   <= 1'b0;
      last_we_q   <= 1'b0;
      pc_q        <= '0;
      halted_q    <= 1'b0;
    end else if (adv) begin
      ex_valid_q  <= accept;
      mem_valid_q <= ex_valid_q;
      m_valid_q   <= mem_valid_q;
      last_we_q   <= rf_we;
      if (ex_valid_q) begin
        pc_q     <= ex_res.next_pc;
        halted_q <= halted_q || ex_res.halt_set;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_instr_q   <= in_instr;
      ex_cval_q    <= in_cval;
      ra_q         <= ra_new;
      rb_q         <= rb_new;
      ds_raddr_q   <= ex_res.ds_addr;
      mem_q        <= ex_res;
      last_waddr_q <= rf_waddr;
      last_wdata_q <= rf_wdata;
      m_data_q     <= {5'd0, mem_q.call_arg, mem_q.call_code, mem_q.status,
                       mem_q.next_pc};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // ---------------- assertions ----------------
  a_no_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (rf_waddr != mss_pkg::REG_ZERO))
    else $error("write to register zero");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag dropped");

  a_pc_moves_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && ex_valid_q) |=> $stable(pc_q))
    else $error("pc changed without an executed instruction");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!ex_valid_q && !mem_valid_q && !ds_raddr_q[0] ||
                    !ex_valid_q && !mem_valid_q))
    else $error("instruction in flight during data store clear");

  a_halted_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_valid_q && halted_q) |-> (ex_res.status == mss_pkg::ST_HALTED &&
                                  !ex_res.wr_en && !ex_res.ds_we))
    else $error("state change while halted");

endmodule

// ===== src/mss_ram.sv =====
module mss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read in the write cycle returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mss_exec.sv =====
module mss_exec (
  input  logic [31:0]     instr_i,
  input  logic [31:0]     cval_i,
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  input  logic [31:0]     pc_i,
  input  logic            halted_i,
  output mss_pkg::ex_res_t res_o
);

  logic [5:0]  op;
  logic [5:0]  funct;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [15:0] uimm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] br_tgt;
  logic [31:0] j_tgt;
  logic [31:0] ea;

  assign op     = instr_i[31:26];
  assign funct  = instr_i[5:0];
  assign rt     = instr_i[20:16];
  assign rd     = instr_i[15:11];
  assign uimm   = instr_i[15:0];
  assign simm   = {{16{uimm[15]}}, uimm};
  assign pc4    = pc_i + 32'd4;
  assign br_tgt = pc4 + {simm[29:0], 2'b00};
  assign j_tgt  = {pc4[31:28], instr_i[25:0], 2'b00};
  assign ea     = a_i + simm;

  always_comb begin
    res_o          = '0;
    res_o.next_pc  = pc4;
    res_o.status   = mss_pkg::ST_OK;
    res_o.wr_addr  = rt;
    res_o.ds_addr  = ea[2 +: mss_pkg::DS_AW];
    res_o.ds_wdata = b_i;
    if (halted_i) begin
      res_o.next_pc = pc_i;
      res_o.status  = mss_pkg::ST_HALTED;
    end else begin
      case (op)
        mss_pkg::OP_SPECIAL: begin
          res_o.wr_addr = rd;
          case (funct)
            mss_pkg::FN_ADD: begin
              res_o.wr_en   = 1'b1;
              res_o.wr_data = a_i + b_i;
            end
            mss_pkg::FN_SUB: begin
              res_o.wr_en   = 1'b1;
              res_o.wr_data = a_i - b_i;
            end
            mss_pkg::FN_AND: begin
              res_o.wr_en   = 1'b1;
              res_o.wr_data = a_i & b_i;
            end
            mss_pkg::FN_OR: begin
              res_o.wr_en   = 1'b1;
              res_o.wr_data = a_i | b_i;
            end
            mss_pkg::FN_SYSCALL: begin
              // operands were read from $v0 and $a0
              res_o.call_code = a_i[7:0];
              res_o.call_arg  = b_i;
              case (a_i[7:0])
                mss_pkg::SYS_PRINT_INT, mss_pkg::SYS_PRINT_STRING,
                mss_pkg::SYS_READ_STRING, mss_pkg::SYS_PRINT_CHAR,
                mss_pkg::SYS_READ_CHAR: begin
                  res_o.status = mss_pkg::ST_EVENT;
                end
                mss_pkg::SYS_INPUT_INT: begin
                  res_o.status  = mss_pkg::ST_EVENT;
                  res_o.wr_en   = 1'b1;
                  res_o.wr_addr = mss_pkg::REG_V0;
                  res_o.wr_data = cval_i;
                end
                mss_pkg::SYS_EXIT: begin
                  res_o.status   = mss_pkg::ST_HALTED;
                  res_o.halt_set = 1'b1;
                end
                default: begin
                  res_o.status  = mss_pkg::ST_BADCALL;
                  res_o.next_pc = pc_i;
                end
              endcase
            end
            default: begin
              res_o.status  = mss_pkg::ST_ILLEGAL;
              res_o.next_pc = pc_i;
            end
          endcase
        end
        mss_pkg::OP_LW: begin
          res_o.wr_en   = 1'b1;
          res_o.is_load = 1'b1;
        end
        mss_pkg::OP_SW: begin
          res_o.ds_we = 1'b1;
        end
        mss_pkg::OP_LUI: begin
          res_o.wr_en   = 1'b1;
          res_o.wr_data = {uimm, 16'h0000};
        end
        mss_pkg::OP_ANDI: begin
          res_o.wr_en   = 1'b1;
          res_o.wr_data = a_i & {16'h0000, uimm};
        end
        mss_pkg::OP_ORI: begin
          res_o.wr_en   = 1'b1;
          res_o.wr_data = a_i | {16'h0000, uimm};
        end
        mss_pkg::OP_NORI: begin
          res_o.wr_en   = 1'b1;
          res_o.wr_data = ~(a_i | {16'h0000, uimm});
        end
        mss_pkg::OP_SLTI: begin
          res_o.wr_en   = 1'b1;
          res_o.wr_data = {31'd0, ($signed(a_i) < $signed(simm))};
        end
        mss_pkg::OP_BEQ: begin
          if (a_i == b_i) begin
            res_o.next_pc = br_tgt;
          end
        end
        mss_pkg::OP_BNE: begin
          if (a_i != b_i) begin
            res_o.next_pc = br_tgt;
          end
        end
        mss_pkg::OP_BGTZ: begin
          if ($signed(a_i) > $signed(32'd0)) begin
            res_o.next_pc = br_tgt;
          end
        end
        mss_pkg::OP_J: begin
          res_o.next_pc = j_tgt;
        end
        mss_pkg::OP_JAL: begin
          res_o.next_pc = j_tgt;
          res_o.wr_en   = 1'b1;
          res_o.wr_addr = mss_pkg::REG_RA;
          res_o.wr_data = pc4;
        end
        default: begin
          res_o.status  = mss_pkg::ST_ILLEGAL;
          res_o.next_pc = pc_i;
        end
      endcase
    end
    // $zero is never written
    res_o.wr_en = res_o.wr_en && (res_o.wr_addr != mss_pkg::REG_ZERO);
  end

endmodule

// ===== bench/mips_subset_instruction_step_top_tb.sv =====
module mips_subset_instruction_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int N_RANDOM     = 700;     // random beats after the directed block
  localparam int QUIET_TAIL   = 100;     // last beats run with no idling at all
  localparam int HOLD_AT      = 250;     // accepted beats before the long sink hold
  localparam int HOLD_CYCLES  = 300;     // long enough to back up the whole pipe
  localparam int DRAIN_CYCLES = 12;      // margin after the last predicted result has come back
  localparam int CYCLE_LIMIT  = 200_000; // clear pass + worst stalls, many times over

  // Encodings the block must reject, and a syscall code it must refuse
  localparam logic [5:0] OP_UNUSED   = 6'h3F;
  localparam logic [5:0] FN_UNUSED   = 6'h3F;
  localparam logic [7:0] SYS_UNKNOWN = 8'hFF;

  localparam logic [3:0][5:0] ALU_FNS = {mss_pkg::FN_OR, mss_pkg::FN_AND,
                                         mss_pkg::FN_SUB, mss_pkg::FN_ADD};
  localparam logic [4:0][5:0] IMM_OPS = {mss_pkg::OP_SLTI, mss_pkg::OP_NORI,
                                         mss_pkg::OP_ORI, mss_pkg::OP_ANDI,
                                         mss_pkg::OP_LUI};
  localparam logic [2:0][5:0] BR_OPS  = {mss_pkg::OP_BGTZ, mss_pkg::OP_BNE,
                                         mss_pkg::OP_BEQ};
  localparam logic [5:0][7:0] EVENT_CODES = {mss_pkg::SYS_READ_CHAR,
                                             mss_pkg::SYS_PRINT_CHAR,
                                             mss_pkg::SYS_READ_STRING,
                                             mss_pkg::SYS_INPUT_INT,
                                             mss_pkg::SYS_PRINT_STRING,
                                             mss_pkg::SYS_PRINT_INT};

  // One s_axis beat: console value rides above the instruction word
  typedef struct packed {
    logic [31:0] console;
    logic [31:0] instr;
  } fetch_t;

  // What one retired instruction reports on m_axis
  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic [7:0]  call_code;
    logic [31:0] call_arg;
  } retire_t;

  logic                            clk_i    = 1'b0;
  logic                            rst_ni   = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [mss_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b1;
  logic [mss_pkg::OUT_TDATA_W-1:0] m_tdata;

  // Shadow of the architectural state, advanced once per accepted beat
  logic [31:0] prog_ctr;
  logic [31:0] gpr  [mss_pkg::RF_DEPTH];
  logic [31:0] dmem [mss_pkg::DATA_WORDS];
  logic        halted;

  fetch_t  instr_q[$];   // beats waiting to be offered
  retire_t retire_q[$];  // predicted results, oldest first

  int n_accepted = 0;
  int n_total    = 0;
  int n_err      = 0;
  int cycle_cnt  = 0;
  int send_idle  = 0;
  int rx_stall   = 0;
  logic long_hold_done = 1'b0;
  logic quiet;

  assign quiet = (n_accepted >= n_total - QUIET_TAIL);

  always #2 clk_i = ~clk_i;

  mips_subset_instruction_step_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor: executes one instruction against the shadow state.
  // ---------------------------------------------------------------------------
  function automatic retire_t retire_instr(logic [31:0] iw, logic [31:0] cval);
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, wr_idx;
    logic [31:0] a, b, pc4, simm, uimm, br_tgt, ea, wr_val;
    logic        wr_en;
    retire_t     r;
    op     = iw[31:26];
    rs     = iw[25:21];
    rt     = iw[20:16];
    rd     = iw[15:11];
    fn     = iw[5:0];
    a      = gpr[rs];
    b      = gpr[rt];
    pc4    = prog_ctr + 32'd4;
    simm   = {{16{iw[15]}}, iw[15:0]};
    uimm   = {16'h0000, iw[15:0]};
    br_tgt = pc4 + (simm << 2);
    ea     = a + simm;
    wr_en  = 1'b0;
    wr_idx = rt;
    wr_val = '0;
    r.next_pc   = pc4;
    r.status    = mss_pkg::ST_OK;
    r.call_code = '0;
    r.call_arg  = '0;

    if (halted) begin
      // frozen for good: report the held PC, touch nothing
      r.next_pc = prog_ctr;
      r.status  = mss_pkg::ST_HALTED;
    end else if (op == mss_pkg::OP_SPECIAL) begin
      wr_idx = rd;
      case (fn)
        mss_pkg::FN_ADD: begin wr_en = 1'b1; wr_val = a + b; end
        mss_pkg::FN_SUB: begin wr_en = 1'b1; wr_val = a - b; end
        mss_pkg::FN_AND: begin wr_en = 1'b1; wr_val = a & b; end
        mss_pkg::FN_OR:  begin wr_en = 1'b1; wr_val = a | b; end
        mss_pkg::FN_SYSCALL: begin
          r.call_code = gpr[mss_pkg::REG_V0][7:0];
          r.call_arg  = gpr[mss_pkg::REG_A0];
          case (r.call_code)
            mss_pkg::SYS_PRINT_INT, mss_pkg::SYS_PRINT_STRING, mss_pkg::SYS_READ_STRING,
            mss_pkg::SYS_PRINT_CHAR, mss_pkg::SYS_READ_CHAR: r.status = mss_pkg::ST_EVENT;
            mss_pkg::SYS_INPUT_INT: begin
              wr_en    = 1'b1;
              wr_idx   = mss_pkg::REG_V0;
              wr_val   = cval;
              r.status = mss_pkg::ST_EVENT;
            end
            mss_pkg::SYS_EXIT: begin
              halted   = 1'b1;
              r.status = mss_pkg::ST_HALTED;
            end
            default: begin
              r.status  = mss_pkg::ST_BADCALL;
              r.next_pc = prog_ctr;
            end
          endcase
        end
        default: begin
          r.status  = mss_pkg::ST_ILLEGAL;
          r.next_pc = prog_ctr;
        end
      endcase
    end else begin
      case (op)
        mss_pkg::OP_LW: begin
          wr_en  = 1'b1;
          wr_val = dmem[ea[mss_pkg::DS_AW+1:2]];
        end
        mss_pkg::OP_SW:   dmem[ea[mss_pkg::DS_AW+1:2]] = b;
        mss_pkg::OP_LUI:  begin wr_en = 1'b1; wr_val = {iw[15:0], 16'h0000}; end
        mss_pkg::OP_ANDI: begin wr_en = 1'b1; wr_val = a & uimm; end
        mss_pkg::OP_ORI:  begin wr_en = 1'b1; wr_val = a | uimm; end
        mss_pkg::OP_NORI: begin wr_en = 1'b1; wr_val = ~(a | uimm); end
        mss_pkg::OP_SLTI: begin
          wr_en  = 1'b1;
          wr_val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        end
        mss_pkg::OP_BEQ:  if (a == b) r.next_pc = br_tgt;
        mss_pkg::OP_BNE:  if (a != b) r.next_pc = br_tgt;
        mss_pkg::OP_BGTZ: if ($signed(a) > 0) r.next_pc = br_tgt;
        mss_pkg::OP_J:    r.next_pc = {pc4[31:28], iw[25:0], 2'b00};
        mss_pkg::OP_JAL: begin
          wr_en     = 1'b1;
          wr_idx    = mss_pkg::REG_RA;
          wr_val    = pc4;
          r.next_pc = {pc4[31:28], iw[25:0], 2'b00};
        end
        default: begin
          r.status  = mss_pkg::ST_ILLEGAL;
          r.next_pc = prog_ctr;
        end
      endcase
    end

    // $zero swallows writes
    if (wr_en && wr_idx != mss_pkg::REG_ZERO) gpr[wr_idx] = wr_val;
    prog_ctr = r.next_pc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [5:0] fn);
    // shamt is don't-care, so randomize it
    return {mss_pkg::OP_SPECIAL, rs, rt, rd, 5'($urandom), fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Mostly a small working set so values get reused, sometimes any register
  function automatic logic [4:0] pick_reg();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 5'($urandom_range(0, 7));
    if (sel == 7) return mss_pkg::REG_RA;
    return 5'($urandom);
  endfunction

  function automatic logic [15:0] pick_imm();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    v   = $urandom_range(0, 32);
    v   = v - 16;
    case (sel)
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3, 4: return 16'(v);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_instr(logic [31:0] iw, logic [31:0] cval);
    fetch_t f;
    f.instr   = iw;
    f.console = cval;
    instr_q.push_back(f);
  endtask

  // Load $v0 so its low byte is the code, then trap. Upper bits are junk on purpose.
  task automatic push_syscall(logic [7:0] code);
    if ($urandom_range(0, 3) == 0) begin
      push_instr(i_word(mss_pkg::OP_LUI, pick_reg(), mss_pkg::REG_V0, 16'($urandom)),
                 $urandom());
      push_instr(i_word(mss_pkg::OP_ORI, mss_pkg::REG_V0, mss_pkg::REG_V0,
                        {8'($urandom), code}), $urandom());
    end else begin
      push_instr(i_word(mss_pkg::OP_ORI, mss_pkg::REG_ZERO, mss_pkg::REG_V0,
                        {8'($urandom), code}), $urandom());
    end
    push_instr({mss_pkg::OP_SPECIAL, 20'($urandom), mss_pkg::FN_SYSCALL}, $urandom());
  endtask

  // One random instruction, or a short well-formed sequence for syscalls.
  // Exit is never generated here; it closes the run.
  task automatic push_random_seq();
    int          kind;
    int          sel;
    logic [31:0] w;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [7:0]  code;
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      push_instr(r_word(pick_reg(), pick_reg(), pick_reg(), ALU_FNS[$urandom_range(0, 3)]),
                 $urandom());
    end else if (kind < 48) begin
      push_instr(i_word(IMM_OPS[$urandom_range(0, 4)], pick_reg(), pick_reg(), pick_imm()),
                 $urandom());
    end else if (kind < 66) begin
      // memory: half of them hit the first 16 words so loads see earlier stores
      sel = $urandom_range(0, 3);
      if (sel < 2) begin
        rs  = mss_pkg::REG_ZERO;
        imm = 16'($urandom_range(0, 63));
      end else if (sel == 2) begin
        rs  = pick_reg();
        imm = pick_imm();
      end else begin
        rs  = 5'($urandom);
        imm = 16'($urandom);
      end
      op = ($urandom_range(0, 1) == 1) ? mss_pkg::OP_SW : mss_pkg::OP_LW;
      push_instr(i_word(op, rs, pick_reg(), imm), $urandom());
    end else if (kind < 76) begin
      rs = pick_reg();
      rt = ($urandom_range(0, 2) == 0) ? rs : pick_reg();
      push_instr(i_word(BR_OPS[$urandom_range(0, 2)], rs, rt, pick_imm()), $urandom());
    end else if (kind < 80) begin
      op = ($urandom_range(0, 1) == 1) ? mss_pkg::OP_JAL : mss_pkg::OP_J;
      push_instr({op, 26'($urandom)}, $urandom());
    end else if (kind < 90) begin
      if ($urandom_range(0, 3) == 0) begin
        code = 8'($urandom);
        if (code inside {mss_pkg::SYS_PRINT_INT, mss_pkg::SYS_PRINT_STRING,
                         mss_pkg::SYS_INPUT_INT, mss_pkg::SYS_READ_STRING,
                         mss_pkg::SYS_EXIT, mss_pkg::SYS_PRINT_CHAR,
                         mss_pkg::SYS_READ_CHAR})
          code = SYS_UNKNOWN;
      end else begin
        code = EVENT_CODES[$urandom_range(0, 5)];
      end
      push_syscall(code);
    end else if (kind < 93) begin
      op = 6'($urandom);
      if (op inside {mss_pkg::OP_SPECIAL, mss_pkg::OP_J, mss_pkg::OP_JAL, mss_pkg::OP_BEQ,
                     mss_pkg::OP_BNE, mss_pkg::OP_BGTZ, mss_pkg::OP_SLTI, mss_pkg::OP_ANDI,
                     mss_pkg::OP_ORI, mss_pkg::OP_NORI, mss_pkg::OP_LUI, mss_pkg::OP_LW,
                     mss_pkg::OP_SW})
        op = OP_UNUSED;
      push_instr({op, 26'($urandom)}, $urandom());
    end else if (kind < 96) begin
      fn = 6'($urandom);
      if (fn inside {mss_pkg::FN_ADD, mss_pkg::FN_SUB, mss_pkg::FN_AND, mss_pkg::FN_OR,
                     mss_pkg::FN_SYSCALL}) fn = FN_UNUSED;
      push_instr(r_word(5'($urandom), 5'($urandom), 5'($urandom), fn), $urandom());
    end else begin
      // raw noise, but never a bare syscall ($v0 could hold the exit code)
      w = $urandom();
      if (w[31:26] == mss_pkg::OP_SPECIAL && w[5:0] == mss_pkg::FN_SYSCALL)
        w[5:0] = FN_UNUSED;
      push_instr(w, $urandom());
    end
  endtask

  // Idle density moves through phases so both dense and sparse stretches occur
  function automatic int idle_pct(int n);
    case ((n / 90) % 3)
      0:       return 10;
      1:       return 0;
      default: return 35;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: offers queued beats, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
      send_idle <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        retire_q.push_back(retire_instr(s_tdata[31:0], s_tdata[63:32]));
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_idle > 0) begin
          send_idle <= send_idle - 1;
          s_tvalid  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct(n_accepted)) begin
          // idle burst: tvalid stays low while send_idle counts down
          send_idle <= $urandom_range(0, 10);
          s_tvalid  <= 1'b0;
        end else if (instr_q.size() != 0) begin
          s_tdata  <= instr_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink side ready: short random stalls, plus one long hold that backs the
  // pipeline up until s_axis_tready drops while the source keeps offering.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready       <= 1'b1;
      rx_stall       <= 0;
      long_hold_done <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= (rx_stall == 1);
    end else if (!long_hold_done && n_accepted >= HOLD_AT) begin
      long_hold_done <= 1'b1;
      rx_stall       <= HOLD_CYCLES;
      m_tready       <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct(n_accepted + 45)) begin
      rx_stall <= $urandom_range(1, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every m_axis beat against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, what, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    retire_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (retire_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual 0x%020h",
                 $time, m_tdata);
        n_err++;
      end else begin
        want = retire_q.pop_front();
        check_field("next_pc", want.next_pc, m_tdata[31:0]);
        check_field("status", 32'(want.status), 32'(m_tdata[34:32]));
        check_field("call_code", 32'(want.call_code), 32'(m_tdata[42:35]));
        check_field("call_argument", want.call_arg, m_tdata[74:43]);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("mips_subset_instruction_step_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Program: directed corner cases, random body, exit, then a halted tail
  // ---------------------------------------------------------------------------
  initial begin
    int n_dir;
    prog_ctr = '0;
    halted   = 1'b0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;

    // extreme operands and wraparound
    push_instr(i_word(mss_pkg::OP_LUI, mss_pkg::REG_ZERO, 5'd1, 16'h8000),
               $urandom());                                     // $1 = 0x80000000
    push_instr(i_word(mss_pkg::OP_NORI, mss_pkg::REG_ZERO, 5'd2, 16'h0000),
               $urandom());                                     // $2 = all ones
    push_instr(r_word(5'd1, 5'd2, 5'd3, mss_pkg::FN_ADD), $urandom());   // 0x7fffffff
    push_instr(r_word(5'd3, 5'd2, mss_pkg::REG_A0, mss_pkg::FN_SUB),
               $urandom());                                     // wraps to 0x80000000
    push_instr(r_word(5'd2, 5'd3, 5'd6, mss_pkg::FN_AND), $urandom());
    push_instr(r_word(5'd1, 5'd3, 5'd7, mss_pkg::FN_OR), $urandom());
    // logical immediates zero-extend, slti sign-extends
    push_instr(i_word(mss_pkg::OP_ANDI, 5'd2, 5'd8, 16'hFFFF), $urandom());
    push_instr(i_word(mss_pkg::OP_ORI, mss_pkg::REG_ZERO, 5'd9, 16'h8000), $urandom());
    push_instr(i_word(mss_pkg::OP_SLTI, 5'd1, 5'd10, 16'hFFFF), $urandom());
    push_instr(i_word(mss_pkg::OP_SLTI, 5'd3, 5'd11, 16'h8000), $urandom());
    // write to $zero dropped; the beq only branches if $zero still reads 0
    push_instr(r_word(5'd2, 5'd2, mss_pkg::REG_ZERO, mss_pkg::FN_ADD), $urandom());
    push_instr(i_word(mss_pkg::OP_BEQ, mss_pkg::REG_ZERO, 5'd11, 16'hFFFF), $urandom());
    // store wraps to the top word; unaligned load finds it there
    push_instr(i_word(mss_pkg::OP_SW, mss_pkg::REG_ZERO, 5'd2, 16'hFFFC), $urandom());
    push_instr(i_word(mss_pkg::OP_LW, mss_pkg::REG_ZERO, 5'd12, 16'h0FFF), $urandom());
    // branches: farthest forward, farthest back, not taken on negative and zero
    push_instr(i_word(mss_pkg::OP_BNE, 5'd1, 5'd2, 16'h7FFF), $urandom());
    push_instr(i_word(mss_pkg::OP_BGTZ, 5'd3, mss_pkg::REG_ZERO, 16'h8000), $urandom());
    push_instr(i_word(mss_pkg::OP_BGTZ, 5'd1, mss_pkg::REG_ZERO, 16'h0001), $urandom());
    push_instr(i_word(mss_pkg::OP_BGTZ, mss_pkg::REG_ZERO, mss_pkg::REG_ZERO, 16'h0001),
               $urandom());
    push_instr({mss_pkg::OP_J, 26'h3FF_FFFF}, $urandom());
    push_instr({mss_pkg::OP_JAL, 26'h000_0000}, $urandom());
    // illegal opcode and illegal funct
    push_instr(32'hFFFF_FFFF, $urandom());
    push_instr(r_word(5'd31, 5'd31, 5'd31, FN_UNUSED), $urandom());
    // $v0 = all ones, so the code is 0xff: refused, PC holds
    push_instr({mss_pkg::OP_SPECIAL, 20'hF_FFFF, mss_pkg::FN_SYSCALL}, $urandom());
    // integer input syscall with the most negative console value
    push_instr(i_word(mss_pkg::OP_ORI, mss_pkg::REG_ZERO, mss_pkg::REG_V0,
                      {8'h00, mss_pkg::SYS_INPUT_INT}), $urandom());
    push_instr({mss_pkg::OP_SPECIAL, 20'h0_0000, mss_pkg::FN_SYSCALL}, 32'h8000_0000);
    n_dir = instr_q.size();

    while (instr_q.size() < n_dir + N_RANDOM) push_random_seq();

    // exit, then everything after it must come back halted
    push_syscall(mss_pkg::SYS_EXIT);
    repeat (4) push_instr($urandom(), $urandom());
    n_total = instr_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (instr_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (retire_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_err == 0) begin
      $display("mips_subset_instruction_step_top regression: pass");
    end else begin
      $display("mips_subset_instruction_step_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mss_pkg.sv
src/mss_ram.sv
src/mss_exec.sv
src/mips_subset_instruction_step_top.sv
bench/mips_subset_instruction_step_top_tb.sv
